// File: src/fht_pkg.sv
// shared types and constants for the chained hash table
// no dependencies
package fht_pkg;

    localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
    localparam int          FNV_PRIME_SH = 40;

    typedef enum logic [1:0] {
        F_GET    = 2'd0,
        F_SET    = 2'd1,
        F_REMOVE = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_MISSING   = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_OVERWRITE = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        H_IDLE,
        H_MIX,
        H_MOD,
        H_DONE
    } t_hash_state;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_HEADQ,
        S_NODE,
        S_CMP,
        S_ACT,
        S_ALLOC,
        S_LINK,
        S_DONE
    } t_state;

    function automatic logic [3:0] f_clamp(input logic [3:0] n);
        logic [3:0] r;
        begin
            r = n;
            if (n == 4'd0) begin
                r = 4'd1;
            end else if (n > 4'd8) begin
                r = 4'd8;
            end
            return r;
        end
    endfunction

    function automatic logic [63:0] f_mask(input logic [3:0] n);
        logic [63:0] m;
        begin
            m = '0;
            for (int i = 0; i < 8; i++) begin
                if (4'(i) < n) begin
                    m[i*8 +: 8] = 8'hff;
                end
            end
            return m;
        end
    endfunction

endpackage

// File: src/fht_req_if.sv
// request channel: operation, key and value
// no dependencies
interface fht_req_if;
    logic             valid;
    logic             ready;
    logic [1:0]       func;
    logic [63:0]      key;
    logic [63:0]      value;
    logic [3:0]       value_bytes;
    modport source (output valid, func, key, value, value_bytes, input ready);
    modport sink   (input valid, func, key, value, value_bytes, output ready);
endinterface

// File: src/fht_rsp_if.sv
// response channel: status, found value and entry count
// no dependencies
interface fht_rsp_if;
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [63:0]      found_value;
    logic [3:0]       found_bytes;
    logic [8:0]       stored_count;
    modport source (output valid, status, found_value, found_bytes, stored_count,
                    input ready);
    modport sink   (input valid, status, found_value, found_bytes, stored_count,
                    output ready);
endinterface

// File: src/fht_cfg_if.sv
// configuration write channel for key_bytes
// no dependencies
interface fht_cfg_if;
    logic             valid;
    logic             ready;
    logic [3:0]       data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: src/fnv1a_chained_hash_table_top.sv
// chained hash table: request sequencer, bucket heads, node pool, free stack
// depends on fht_pkg, fht_req_if, fht_rsp_if, fht_cfg_if, fht_hash
//
//  channel  dir  carries
//  i_req    in   func, key, value, value_bytes
//  o_rsp    out  status, found_value, found_bytes, stored_count
//  i_cfg    in   key_bytes
//
// an item runs the hash start, one hash step per key byte, the bucket remainder and
// handoff, then the head read, a compare for each chain node, the update and the result;
// an insert adds an alloc and a link step; all items share the one hash multiplier
// after reset a clearing pass over the bucket heads and free stack runs before the first item
// a waiting result does not block the next item; the next result waits for the output
module fnv1a_chained_hash_table_top #(
    parameter int BUCKETS = 256,
    parameter int NODES   = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fht_req_if.sink     i_req,
    fht_rsp_if.source   o_rsp,
    fht_cfg_if.sink     i_cfg
);
    import fht_pkg::*;

    localparam int NW  = $clog2(NODES + 1);
    localparam int IW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CL  = (BUCKETS > NODES) ? BUCKETS : NODES;
    localparam int CLW = $clog2(CL + 1);
    localparam logic [NW-1:0] NIL = NW'(NODES);

    t_state r_state, n_state;

    logic [NW-1:0] mem_head  [BUCKETS];
    logic [63:0]   mem_key   [NODES];
    logic [63:0]   mem_val   [NODES];
    logic [3:0]    mem_size  [NODES];
    logic [NW-1:0] mem_link  [NODES];
    logic [IW-1:0] mem_stack [NODES];

    logic [NW-1:0] rd_head;
    logic [63:0]   rd_key;
    logic [63:0]   rd_val;
    logic [3:0]    rd_size;
    logic [NW-1:0] rd_link;
    logic [IW-1:0] rd_stack;

    logic [CLW-1:0] r_clr;
    logic [3:0]     r_key_bytes;
    logic [1:0]     r_func;
    logic [63:0]    r_key;
    logic [63:0]    r_value;
    logic [3:0]     r_vb;
    logic [3:0]     r_kb;
    logic [BW-1:0]  r_bucket;
    logic [NW-1:0]  r_cur;
    logic [NW-1:0]  r_prev;
    logic [IW-1:0]  r_new;
    logic [NW-1:0]  r_free_top;
    logic [NW-1:0]  r_entries;
    logic [2:0]     r_status;
    logic [63:0]    r_fval;
    logic [3:0]     r_fbytes;
    logic           r_ovalid;
    logic [2:0]     r_ostatus;
    logic [63:0]    r_ofval;
    logic [3:0]     r_ofbytes;
    logic [8:0]     r_ocount;

    logic           hash_start;
    logic           hash_done;
    logic [BW-1:0]  hash_bucket;
    logic           key_match;
    logic           out_load;
    logic [NW+8:0]  count_ext;
    logic [IW-1:0]  stack_ra;

    logic           head_we;
    logic [BW-1:0]  head_wa;
    logic [NW-1:0]  head_wd;
    logic           link_we;
    logic [IW-1:0]  link_wa;
    logic [NW-1:0]  link_wd;
    logic           stack_we;
    logic [IW-1:0]  stack_wa;
    logic [IW-1:0]  stack_wd;
    logic           nval_we;
    logic           nkey_we;
    logic [IW-1:0]  node_wa;

    fht_hash #(.BUCKETS(BUCKETS)) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_key    (r_key),
        .i_kb     (r_kb),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign hash_start  = (r_state == S_HASH);
    assign key_match   = (((rd_key ^ r_key) & f_mask(r_kb)) == 64'd0);
    assign out_load    = (r_state == S_DONE) && (!r_ovalid || o_rsp.ready);
    assign count_ext   = {9'b0, r_entries};
    assign stack_ra    = IW'(r_free_top - NW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == CLW'(CL - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_req.valid) n_state = S_HASH;
            S_HASH:  if (hash_done) n_state = S_HEAD;
            S_HEAD:  n_state = S_HEADQ;
            S_HEADQ: n_state = S_NODE;
            S_NODE:  n_state = (r_cur == NIL) ? S_ACT : S_CMP;
            S_CMP:   n_state = key_match ? S_ACT : S_NODE;
            S_ACT: begin
                n_state = S_DONE;
                if (r_func == F_SET && r_cur == NIL && r_free_top != '0) begin
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: n_state = S_LINK;
            S_LINK:  n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory write controls
    always_comb begin
        head_we  = 1'b0;
        head_wa  = r_bucket;
        head_wd  = rd_link;
        link_we  = 1'b0;
        link_wa  = r_prev[IW-1:0];
        link_wd  = rd_link;
        stack_we = 1'b0;
        stack_wa = r_free_top[IW-1:0];
        stack_wd = r_cur[IW-1:0];
        nval_we  = 1'b0;
        nkey_we  = 1'b0;
        node_wa  = r_cur[IW-1:0];
        case (r_state)
            S_CLEAR: begin
                head_we  = (r_clr < CLW'(BUCKETS));
                head_wa  = r_clr[BW-1:0];
                head_wd  = NIL;
                stack_we = (r_clr < CLW'(NODES));
                stack_wa = r_clr[IW-1:0];
                stack_wd = r_clr[IW-1:0];
            end
            S_ACT: begin
                if (r_func == F_SET && r_cur != NIL) begin
                    nval_we = 1'b1;
                end
                if (r_func == F_REMOVE && r_cur != NIL) begin
                    head_we  = (r_prev == NIL);
                    link_we  = (r_prev != NIL);
                    stack_we = (r_free_top < NIL);
                end
            end
            S_ALLOC: begin
                nval_we = 1'b1;
                nkey_we = 1'b1;
                node_wa = rd_stack;
                link_we = 1'b1;
                link_wa = rd_stack;
                link_wd = NIL;
            end
            S_LINK: begin
                head_we = (r_prev == NIL);
                head_wd = NW'(r_new);
                link_we = (r_prev != NIL);
                link_wd = NW'(r_new);
            end
            default: begin
                head_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (head_we) mem_head[head_wa] <= head_wd;
        rd_head <= mem_head[r_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) mem_link[link_wa] <= link_wd;
        rd_link <= mem_link[r_cur[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) mem_stack[stack_wa] <= stack_wd;
        rd_stack <= mem_stack[stack_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nkey_we) mem_key[node_wa] <= r_key;
        rd_key <= mem_key[r_cur[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (nval_we) begin
            mem_val[node_wa]  <= r_value & f_mask(r_vb);
            mem_size[node_wa] <= r_vb;
        end
        rd_val  <= mem_val[r_cur[IW-1:0]];
        rd_size <= mem_size[r_cur[IW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_key_bytes <= 4'd8;
            r_free_top  <= NIL;
            r_entries   <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + CLW'(1);
            if (i_cfg.valid) r_key_bytes <= i_cfg.data;
            if (r_state == S_ACT && r_func == F_SET && r_cur == NIL
                && r_free_top != '0) begin
                r_free_top <= r_free_top - NW'(1);
                r_entries  <= r_entries + NW'(1);
            end
            if (r_state == S_ACT && r_func == F_REMOVE && r_cur != NIL) begin
                if (r_free_top < NIL) r_free_top <= r_free_top + NW'(1);
                if (r_entries != '0) r_entries <= r_entries - NW'(1);
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_func   <= i_req.func;
                r_key    <= i_req.key;
                r_value  <= i_req.value;
                r_vb     <= f_clamp(i_req.value_bytes);
                r_kb     <= f_clamp(r_key_bytes);
                r_status <= ST_MISSING;
                r_fval   <= '0;
                r_fbytes <= '0;
            end
            S_HASH: r_bucket <= hash_bucket;
            S_HEADQ: begin
                r_cur  <= rd_head;
                r_prev <= NIL;
            end
            S_CMP: begin
                if (!key_match) begin
                    r_prev <= r_cur;
                    r_cur  <= rd_link;
                end
            end
            S_ACT: begin
                case (r_func)
                    F_GET: begin
                        if (r_cur != NIL) begin
                            r_status <= ST_FOUND;
                            r_fval   <= rd_val;
                            r_fbytes <= rd_size;
                        end
                    end
                    F_SET: begin
                        if (r_cur != NIL) begin
                            r_status <= ST_OVERWRITE;
                        end else if (r_free_top == '0) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status <= ST_INSERTED;
                        end
                    end
                    F_REMOVE: if (r_cur != NIL) r_status <= ST_REMOVED;
                    default:  r_status <= ST_MISSING;
                endcase
            end
            S_ALLOC: r_new <= rd_stack;
            default: r_new <= r_new;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ostatus <= r_status;
            r_ofval   <= r_fval;
            r_ofbytes <= r_fbytes;
            r_ocount  <= count_ext[8:0];
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_ostatus;
    assign o_rsp.found_value  = r_ofval;
    assign o_rsp.found_bytes  = r_ofbytes;
    assign o_rsp.stored_count = r_ocount;

    a_pool_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_entries) + 32'(r_free_top)) == NODES)
        else $error("entry count and free stack disagree");

    a_found_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostatus == ST_FOUND) |-> (r_ofbytes != 4'd0))
        else $error("found item with zero size");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostatus != ST_FOUND) |-> (r_ofval == 64'd0 && r_ofbytes == 4'd0))
        else $error("value reported on a non-found item");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == S_CLEAR) && r_state != S_IDLE |-> !i_req.ready)
        else $error("request taken during clearing pass");

endmodule

// File: src/fht_hash.sv
// fnv-1a 64 over up to 8 key bytes, one byte a cycle, then bucket remainder
// one nibble a cycle; depends on fht_pkg
module fht_hash #(
    parameter int BUCKETS = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [63:0]                            i_key,
    input  logic [3:0]                             i_kb,
    output logic                                   o_done,
    output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] o_bucket
);
    import fht_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int RW = $clog2(BUCKETS) + 5;
    localparam logic [RW-1:0] B1 = RW'(BUCKETS);

    t_hash_state r_state, n_state;
    logic [63:0]   r_h;
    logic [3:0]    r_cnt;
    logic [RW-1:0] r_rem;
    logic [63:0]   mix_x;
    logic [63:0]   mix_h;
    logic [RW-1:0] red;

    assign mix_x = r_h ^ {56'b0, i_key[r_cnt[2:0]*8 +: 8]};
    assign mix_h = (mix_x << FNV_PRIME_SH) + (mix_x * {55'b0, FNV_PRIME_LO});

    always_comb begin
        red = {r_rem[RW-5:0], r_h[r_cnt*4 +: 4]};
        for (int k = 3; k >= 0; k--) begin
            if (red >= (B1 << k)) begin
                red = red - (B1 << k);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            H_IDLE:  if (i_start) n_state = H_MIX;
            H_MIX:   if (r_cnt == i_kb - 4'd1) n_state = H_MOD;
            H_MOD:   if (r_cnt == 4'd0) n_state = H_DONE;
            H_DONE:  n_state = H_IDLE;
            default: n_state = H_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == H_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            H_IDLE: begin
                r_h   <= FNV_BASIS;
                r_cnt <= 4'd0;
                r_rem <= '0;
            end
            H_MIX: begin
                r_h <= mix_h;
                if (r_cnt == i_kb - 4'd1) begin
                    r_cnt <= 4'd15;
                end else begin
                    r_cnt <= r_cnt + 4'd1;
                end
            end
            H_MOD: begin
                r_rem <= red;
                r_cnt <= r_cnt - 4'd1;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_bucket = r_rem[BW-1:0];

endmodule

// File: sim/fnv1a_chained_hash_table_top_test.sv
// testbench for the chained hash table: drives requests and key width writes,
// predicts every response with its own table model and checks all of its fields at once
// depends on fht_pkg, fht_req_if, fht_rsp_if, fht_cfg_if, fnv1a_chained_hash_table_top
`timescale 1ns / 100ps

module fnv1a_chained_hash_table_top_test;
    import fht_pkg::*;

    localparam int NB = 256;
    localparam int NN = 256;
    localparam longint LIMIT = 10000000;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] fvalue;
        logic [3:0]  fbytes;
        logic [8:0]  count;
    } t_rsp;

    class table_scoreboard;
        int          head [NB];
        logic [63:0] nkey [NN];
        logic [63:0] nval [NN];
        logic [3:0]  nsize [NN];
        int          nlink [NN];
        int          free_stack [NN];
        int          free_top;
        int          total;
        logic [3:0]  key_width;
        t_rsp        pending [$];
        int          errors;

        function new();
            for (int i = 0; i < NB; i++) head[i] = NN;
            for (int i = 0; i < NN; i++) begin
                nlink[i] = NN;
                free_stack[i] = i;
            end
            free_top = NN;
            total = 0;
            key_width = 4'd8;
            errors = 0;
        endfunction

        function bit holds(logic [63:0] k);
            logic [63:0] m;
            int b;
            int c;
            int s;
            m = f_mask(f_clamp(key_width));
            b = bucket_of(k);
            c = head[b];
            s = 0;
            while (c < NN && s < NN) begin
                if (((nkey[c] ^ k) & m) == 0) return 1;
                c = nlink[c];
                s++;
            end
            return 0;
        endfunction

        function int bucket_of(logic [63:0] k);
            logic [63:0] h;
            int n;
            h = 64'hcbf29ce484222325;
            n = f_clamp(key_width);
            for (int i = 0; i < n; i++) begin
                h = h ^ ((k >> (8 * i)) & 64'hff);
                h = h * 64'h100000001b3;
            end
            return int'(h % NB);
        endfunction

        function void note_request(logic [1:0] func, logic [63:0] k, logic [63:0] v,
                                   logic [3:0] vb);
            logic [63:0] km;
            logic [3:0]  vn;
            int b;
            int c;
            int p;
            int s;
            int n;
            t_rsp r;
            vn = f_clamp(vb);
            km = f_mask(f_clamp(key_width));
            b = bucket_of(k);
            c = head[b];
            p = NN;
            s = 0;
            r = '0;
            r.status = ST_MISSING;
            while (c < NN && s < NN) begin
                if (((nkey[c] ^ k) & km) == 0) break;
                p = c;
                c = nlink[c];
                s++;
            end
            if (s >= NN) c = NN;
            if (func == F_GET) begin
                if (c < NN) begin
                    r.status = ST_FOUND;
                    r.fvalue = nval[c];
                    r.fbytes = nsize[c];
                end
            end else if (func == F_SET) begin
                if (c < NN) begin
                    nval[c] = v & f_mask(vn);
                    nsize[c] = vn;
                    r.status = ST_OVERWRITE;
                end else if (free_top == 0) begin
                    r.status = ST_FULL;
                end else begin
                    free_top--;
                    n = free_stack[free_top];
                    nkey[n] = k;
                    nval[n] = v & f_mask(vn);
                    nsize[n] = vn;
                    nlink[n] = NN;
                    if (p < NN) nlink[p] = n;
                    else head[b] = n;
                    total++;
                    r.status = ST_INSERTED;
                end
            end else if (func == F_REMOVE) begin
                if (c < NN) begin
                    if (p < NN) nlink[p] = nlink[c];
                    else head[b] = nlink[c];
                    if (free_top < NN) begin
                        free_stack[free_top] = c;
                        free_top++;
                    end
                    if (total > 0) total--;
                    r.status = ST_REMOVED;
                end
            end
            r.count = 9'(total);
            pending.push_back(r);
        endfunction

        function void check_response(t_rsp got);
            t_rsp e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p, got %p", e, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    fht_req_if req ();
    fht_rsp_if rsp ();
    fht_cfg_if cfg ();
    table_scoreboard sb;
    longint cycles;
    logic [63:0] used_keys [$];
    int rsp_gap;

    fnv1a_chained_hash_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .i_cfg   (cfg)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n && rsp.valid && rsp.ready)
            sb.check_response({rsp.status, rsp.found_value, rsp.found_bytes,
                               rsp.stored_count});
    end

    // response stall pattern, including long stretches without stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
        end else if (rsp_gap > 0) begin
            rsp.ready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
        end else begin
            rsp.ready <= 1'b1;
            if (rsp.valid && rsp.ready && (cycles % 4000) > 1500) rsp_gap <= pick_gap();
        end
    end

    task automatic send(logic [1:0] func, logic [63:0] k, logic [63:0] v, logic [3:0] vb);
        int g;
        g = ((cycles % 5000) < 1200) ? 0 : pick_gap();
        if (g > 0) begin
            req.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        req.valid <= 1'b1;
        req.func <= func;
        req.key <= k;
        req.value <= v;
        req.value_bytes <= vb;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        sb.note_request(func, k, v, vb);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_width(logic [3:0] w);
        drain();
        cfg.valid <= 1'b1;
        cfg.data <= w;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        sb.key_width = w;
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(0, 99) < 65)
            return used_keys[$urandom_range(0, used_keys.size() - 1)] ^
                   ($urandom_range(0, 3) == 0 ? {$urandom(), 32'h0} : 64'h0);
        return rand64();
    endfunction

    task automatic random_phase(int n, int key_pool);
        logic [63:0] k;
        logic [1:0]  f;
        for (int i = 0; i < n; i++) begin
            k = pick_key();
            if (key_pool > 0 && $urandom_range(0, 1) == 0)
                k = 64'($urandom_range(0, key_pool - 1)) << (8 * $urandom_range(0, 1));
            f = 2'($urandom_range(0, 99) < 45 ? 1 : $urandom_range(0, 99) < 55 ? 0 :
                   $urandom_range(0, 9) == 0 ? 3 : 2);
            if (f == F_SET) used_keys.push_back(k);
            send(f, k, rand64(), 4'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        logic [3:0] widths [6];
        widths = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5};
        sb = new();
        cycles = 0;
        rsp_gap = 0;
        i_rst_n = 0;
        req.valid = 0;
        req.func = F_GET;
        req.key = '0;
        req.value = '0;
        req.value_bytes = '0;
        cfg.valid = 0;
        cfg.data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty bucket, field extremes, head removal, unused op
        send(F_GET, 64'h0, 64'h0, 4'd0);
        send(F_REMOVE, '1, 64'h0, 4'd8);
        send(F_SET, '1, '1, 4'd15);
        send(F_SET, 64'h0, '1, 4'd0);
        send(F_SET, 64'h0, 64'h0123456789abcdef, 4'd3);
        send(F_GET, 64'h0, 64'h0, 4'd0);
        send(F_GET, '1, 64'h0, 4'd0);
        send(2'd3, '1, '1, 4'd8);
        send(F_REMOVE, '1, 64'h0, 4'd0);
        send(F_GET, '1, 64'h0, 4'd0);
        write_width(4'd1);
        for (int i = 0; i < 4; i++) send(F_SET, 64'(i) << 8 | 64'(i * 37), 64'(i), 4'd8);
        send(F_REMOVE, 64'h0, 64'h0, 4'd1);
        send(F_GET, 64'h25, 64'h0, 4'd1);
        send(F_GET, 64'h0, 64'h0, 4'd1);
        // pool exhaustion at full width
        write_width(4'd8);
        for (int i = 0; i < 260; i++) send(F_SET, rand64(), rand64(), 4'($urandom_range(1, 8)));
        // hold until all results drained
        drain();
        for (int i = 0; i < 60; i++) send(F_REMOVE, pick_key(), 64'h0, 4'd1);

        foreach (widths[w]) begin
            write_width(widths[w]);
            random_phase(200, (widths[w] <= 1) ? 256 : 0);
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
